// ----- sv/vcfe_pkg.sv -----
// Shared types and constants for the voxel column face extractor.
// No dependencies; every other file of the block but vcfe_out_if imports this package.
package vcfe_pkg;

  // Command codes of an input word.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_COLUMN = 1'b1;

  // Column direction codes.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Geometry of the edge masks and the id store.
  localparam int MASK_W   = 32;
  localparam int IDX_W    = 5;
  localparam int COORD_W  = 5;
  localparam int ID_W     = 16;
  localparam int ADDR_W   = 3 * COORD_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // Face word constants.
  localparam logic [2:0] ROT_NEG_OFFSET = 3'd3;
  localparam logic [7:0] FACE_EXTENT    = 8'd8;

  // Queue between front and back, and the output buffer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int OUT_DEPTH   = 4;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);

  // One classified item as it travels from front to back.
  typedef struct packed {
    logic                is_write;
    logic [1:0]          axis;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [COORD_W-1:0]  pos_z;
    logic [ID_W-1:0]     block_id;
    logic [MASK_W-1:0]   pos_edges;
    logic [MASK_W-1:0]   neg_edges;
  } vcfe_entry_t;

  // Status of the queue as seen by its two neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } vcfe_qstat_t;

  // Index of the single set bit of a one-hot mask.
  function automatic logic [IDX_W-1:0] onehot_index(input logic [MASK_W-1:0] onehot);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (onehot[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/vcfe_in_if.sv -----
// Input channel of the face extractor: valid/ready handshake and item fields.
// Depends on vcfe_pkg for field widths.
interface vcfe_in_if;
  import vcfe_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [1:0]         axis;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0] pos_z;
  logic [63:0]        column_mask;
  logic [ID_W-1:0]    block_id;

  modport source (
    output valid, command, axis, pos_x, pos_y, pos_z, column_mask, block_id,
    input  ready
  );

  modport sink (
    input  valid, command, axis, pos_x, pos_y, pos_z, column_mask, block_id,
    output ready
  );
endinterface

// ----- sv/vcfe_out_if.sv -----
// Output channel of the face extractor: valid/ready handshake and face fields.
// No dependencies.
interface vcfe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] face_word;
  logic        last_face;

  modport source (
    output valid, face_word, last_face,
    input  ready
  );

  modport sink (
    input  valid, face_word, last_face,
    output ready
  );
endinterface

// ----- sv/vcfe_front.sv -----
// Front end: accepts input words, forms the edge masks and drops columns
// that produce no faces. Depends on vcfe_pkg and vcfe_in_if.
module vcfe_front
  import vcfe_pkg::*;
#(
  parameter int CHUNK_SIZE = 32
) (
  vcfe_in_if.sink     items,
  input  vcfe_qstat_t qstat,
  output logic        push,
  output vcfe_entry_t entry
);

  logic [63:0]       pos_all;
  logic [63:0]       neg_all;
  logic [MASK_W-1:0] pos_c;
  logic [MASK_W-1:0] neg_c;
  logic              keep;

  // Edge masks; coordinate c sits at mask bit c+1, outside bits only act as neighbors.
  always_comb begin
    pos_all = items.column_mask & ~(items.column_mask >> 1);
    neg_all = items.column_mask & ~(items.column_mask << 1);
    for (int c = 0; c < MASK_W; c++) begin
      pos_c[c] = (c < CHUNK_SIZE) ? pos_all[c+1] : 1'b0;
      neg_c[c] = (c < CHUNK_SIZE) ? neg_all[c+1] : 1'b0;
    end
  end

  // Writes always go on; columns go on only with a valid axis and some edge.
  always_comb begin
    keep = (items.command == CMD_WRITE) ||
           ((items.axis != AXIS_NONE) && ((pos_c | neg_c) != '0));
    items.ready = !qstat.full;
    push        = items.valid && !qstat.full && keep;
  end

  // Queue entry.
  always_comb begin
    entry.is_write  = (items.command == CMD_WRITE);
    entry.axis      = items.axis;
    entry.pos_x     = items.pos_x;
    entry.pos_y     = items.pos_y;
    entry.pos_z     = items.pos_z;
    entry.block_id  = items.block_id;
    entry.pos_edges = pos_c;
    entry.neg_edges = neg_c;
  end

endmodule

// ----- sv/vcfe_queue.sv -----
// Short queue of classified entries between front and back.
// Depends on vcfe_pkg.
module vcfe_queue
  import vcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  vcfe_entry_t push_data,
  input  logic        pop,
  output vcfe_entry_t pop_data,
  output vcfe_qstat_t qstat
);

  vcfe_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_comb begin
    qstat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
    qstat.empty = (count == '0);
    pop_data    = slots[rd_ptr];
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- sv/vcfe_back.sv -----
// Back end (depends on vcfe_pkg, vcfe_out_if): owns the block-id store, does
// writes and walks edge masks: one face word per cycle while output room lasts.
module vcfe_back
  import vcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  vcfe_qstat_t qstat,
  input  vcfe_entry_t entry,
  output logic        pop,
  vcfe_out_if.source  faces
);

  // Block-id store.
  logic [ID_W-1:0]    store [STORE_DEPTH];
  logic [ID_W-1:0]    rdata;

  // Column being walked.
  logic               busy;
  logic [1:0]         cur_axis;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [COORD_W-1:0] cur_z;
  logic [MASK_W-1:0]  cur_pos;
  logic [MASK_W-1:0]  cur_neg;

  // Read stage, aligned with the registered store data.
  logic               s1_valid;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic [COORD_W-1:0] s1_z;
  logic [2:0]         s1_rot;
  logic               s1_last;

  // Output buffer.
  logic [63:0]        obuf_word [OUT_DEPTH];
  logic               obuf_last [OUT_DEPTH];
  logic [OPTR_W-1:0]  obuf_wr;
  logic [OPTR_W-1:0]  obuf_rd;
  logic [OPTR_W:0]    obuf_count;

  logic               sel_pos;
  logic [MASK_W-1:0]  sel_mask;
  logic [MASK_W-1:0]  low_bit;
  logic [IDX_W-1:0]   low_idx;
  logic [MASK_W-1:0]  rem_pos;
  logic [MASK_W-1:0]  rem_neg;
  logic               is_last;
  logic               credit;
  logic               issue;
  logic               wr_en;
  logic [COORD_W-1:0] face_x;
  logic [COORD_W-1:0] face_y;
  logic [COORD_W-1:0] face_z;
  logic [2:0]         face_rot;
  logic [63:0]        face_word;
  logic               out_pop;

  // Pick the next face: lowest positive edge first, then lowest negative edge.
  always_comb begin
    sel_pos  = (cur_pos != '0);
    sel_mask = sel_pos ? cur_pos : cur_neg;
    low_bit  = sel_mask & (~sel_mask + 1'b1);
    low_idx  = onehot_index(low_bit);
    rem_pos  = sel_pos ? (cur_pos & ~low_bit) : cur_pos;
    rem_neg  = sel_pos ? cur_neg : (cur_neg & ~low_bit);
    is_last  = ((rem_pos | rem_neg) == '0);
    face_rot = {1'b0, cur_axis} + (sel_pos ? 3'd0 : ROT_NEG_OFFSET);
    face_x   = (cur_axis == AXIS_X) ? low_idx : cur_x;
    face_y   = (cur_axis == AXIS_Y) ? low_idx : cur_y;
    face_z   = (cur_axis == AXIS_Z) ? low_idx : cur_z;
  end

  // A read goes out only when the output buffer has room for it.
  always_comb begin
    credit = (({1'b0, obuf_count} + {{(OPTR_W+1){1'b0}}, s1_valid}) <
              (OPTR_W+2)'(OUT_DEPTH));
    issue  = busy && credit;
    pop    = !busy && !qstat.empty;
    wr_en  = pop && entry.is_write;
  end

  // Column walk control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (issue && is_last) begin
      busy <= 1'b0;
    end else if (pop && !entry.is_write) begin
      busy <= 1'b1;
    end
  end

  // Column payload and remaining edges.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_axis <= entry.axis;
      cur_x    <= entry.pos_x;
      cur_y    <= entry.pos_y;
      cur_z    <= entry.pos_z;
      cur_pos  <= entry.pos_edges;
      cur_neg  <= entry.neg_edges;
    end else if (issue) begin
      cur_pos <= rem_pos;
      cur_neg <= rem_neg;
    end
  end

  // Store: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[{entry.pos_x, entry.pos_y, entry.pos_z}] <= entry.block_id;
    end
    if (issue) begin
      rdata <= store[{face_x, face_y, face_z}];
    end
  end

  // Read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_x    <= face_x;
      s1_y    <= face_y;
      s1_z    <= face_z;
      s1_rot  <= face_rot;
      s1_last <= is_last;
    end
  end

  // Pack the face word.
  always_comb begin
    face_word = {rdata, s1_x, 3'b000, s1_y, 3'b000, s1_z, 3'b000,
                 FACE_EXTENT, FACE_EXTENT, 2'b00, s1_rot, 3'b000};
  end

  // Output buffer handshake.
  always_comb begin
    faces.valid     = (obuf_count != '0);
    faces.face_word = obuf_word[obuf_rd];
    faces.last_face = obuf_last[obuf_rd];
    out_pop         = faces.valid && faces.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_wr    <= '0;
      obuf_rd    <= '0;
      obuf_count <= '0;
    end else begin
      if (s1_valid) begin
        obuf_wr <= obuf_wr + 1'b1;
      end
      if (out_pop) begin
        obuf_rd <= obuf_rd + 1'b1;
      end
      if (s1_valid && !out_pop) begin
        obuf_count <= obuf_count + 1'b1;
      end else if (out_pop && !s1_valid) begin
        obuf_count <= obuf_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      obuf_word[obuf_wr] <= face_word;
      obuf_last[obuf_wr] <= s1_last;
    end
  end

endmodule

// ----- sv/voxel_column_face_extractor.sv -----
// Voxel column face extractor. The front takes one input word per cycle while
// its two-entry queue has room; columns with no edge inside the chunk and
// columns with axis code three are dropped there and never enter the queue.
// The back takes one queue entry at a time: a write item takes effect as it
// is popped, and a column is walked one face after another, since the single
// port of the 32768-entry id store does one read per face. Each face word
// passes the registered store read and the read stage into a four-word output
// buffer, so a stalled output side holds the back only once it fills. The id
// store has no reset; an entry must be written before a face reads it.
// Depends on vcfe_pkg, vcfe_in_if, vcfe_out_if, vcfe_front, vcfe_queue, vcfe_back.
module voxel_column_face_extractor
  import vcfe_pkg::*;
#(
  parameter int CHUNK_SIZE = 32
) (
  input  logic       clk,
  input  logic       rst,
  vcfe_in_if.sink    items,
  vcfe_out_if.source faces
);

  logic        q_push;
  logic        q_pop;
  vcfe_entry_t q_in;
  vcfe_entry_t q_out;
  vcfe_qstat_t q_stat;

  // Classification of incoming words.
  vcfe_front #(
    .CHUNK_SIZE(CHUNK_SIZE)
  ) u_front (
    .items (items),
    .qstat (q_stat),
    .push  (q_push),
    .entry (q_in)
  );

  // Decoupling queue.
  vcfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .qstat     (q_stat)
  );

  // Store access and face generation.
  vcfe_back u_back (
    .clk   (clk),
    .rst   (rst),
    .qstat (q_stat),
    .entry (q_out),
    .pop   (q_pop),
    .faces (faces)
  );

`ifndef SYNTH
  // Width and height bytes are fixed and the low three bits are always zero.
  a_face_const: assert property (@(posedge clk) disable iff (rst)
    faces.valid |-> (faces.face_word[23:8] == {FACE_EXTENT, FACE_EXTENT}) &&
                    (faces.face_word[2:0] == 3'b000))
    else $error("face word constant fields corrupted");

  // Rotation code never exceeds five.
  a_face_rot: assert property (@(posedge clk) disable iff (rst)
    faces.valid |-> (faces.face_word[7:3] != 5'd6) && (faces.face_word[7:3] != 5'd7) &&
                    (faces.face_word[7:6] == 2'b00))
    else $error("face rotation code out of range");

  // The queue is never full and empty at once.
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // No face word is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !faces.valid)
    else $error("output valid after reset");
`endif

endmodule
